[rtl/plol_pkg.sv]
// Shared constants and types for the piecewise-linear opacity lookup.
// No dependencies; plol_blend and the top level import this package.
`timescale 1ns / 1ps

package plol_pkg;

  // Table geometry and number format.
  localparam int unsigned MAX_KNOTS  = 8192;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_KNOTS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned KNOT_W     = 2 * VALUE_BITS;
  localparam int unsigned PROD_W     = 2 * VALUE_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(VALUE_BITS);

  // Operation codes of a request.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      index_t;

  // One table entry as it sits in the knot memory.
  typedef struct packed {
    value_t pos;
    value_t opa;
  } knot_t;

  // Segment handed from the scan to the blend unit.
  typedef struct packed {
    value_t query;
    knot_t  left;
    knot_t  right;
  } blend_req_t;

  // Answer of the blend unit.
  typedef struct packed {
    value_t opacity;
    logic   exact_hit;
  } blend_rsp_t;

endpackage

[rtl/plol_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module plol_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/plol_blend.sv]
// Blend unit: interpolates opacity inside one segment with a shared
// multiplier and a radix-2 restoring divider. Depends on plol_pkg.
`timescale 1ns / 1ps

module plol_blend (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  plol_pkg::blend_req_t req_i,
  output logic                 done_o,
  output plol_pkg::blend_rsp_t rsp_o
);
  import plol_pkg::*;

  localparam logic [1:0] BL_IDLE = 2'd0;
  localparam logic [1:0] BL_MUL1 = 2'd1;
  localparam logic [1:0] BL_MUL2 = 2'd2;
  localparam logic [1:0] BL_DIV  = 2'd3;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(VALUE_BITS - 1);

  logic [1:0]           state_q, state_d;
  logic                 done_q, done_d;
  blend_rsp_t           rsp_q, rsp_d;
  blend_req_t           req_q, req_d;
  value_t               w_q, w_d;
  value_t               d_q, d_d;
  value_t               wd_q, wd_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  value_t               rem_q, rem_d;
  value_t               lo_q, lo_d;
  value_t               quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic [VALUE_BITS-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic [PROD_W:0]       num_sum;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   trial_sub;
  logic                  qbit;
  value_t                w_in, d_in;

  // One multiplier serves both products.
  assign mul_a = (state_q == BL_MUL1) ? req_q.left.opa : req_q.right.opa;
  assign mul_b = (state_q == BL_MUL1) ? wd_q : d_q;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign num_sum = {1'b0, prod_q} + {1'b0, mul_p} + (PROD_W + 1)'(w_q >> 1);

  assign trial     = {rem_q, lo_q[VALUE_BITS-1]};
  assign trial_sub = trial - {1'b0, w_q};
  assign qbit      = (trial >= {1'b0, w_q});

  assign w_in = req_i.right.pos - req_i.left.pos;
  assign d_in = req_i.query - req_i.left.pos;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    req_d   = req_q;
    w_d     = w_q;
    d_d     = d_q;
    wd_d    = wd_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      BL_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          w_d   = w_in;
          d_d   = d_in;
          wd_d  = w_in - d_in;
          // An exact hit and the clamped cases finish at once without the divider.
          priority if (req_i.query == req_i.right.pos) begin
            rsp_d  = '{opacity: req_i.right.opa, exact_hit: 1'b1};
            done_d = 1'b1;
          end else if (req_i.right.pos <= req_i.left.pos) begin
            rsp_d  = '{opacity: req_i.right.opa, exact_hit: 1'b0};
            done_d = 1'b1;
          end else if (req_i.query <= req_i.left.pos) begin
            rsp_d  = '{opacity: req_i.left.opa, exact_hit: 1'b0};
            done_d = 1'b1;
          end else if (req_i.query >= req_i.right.pos) begin
            rsp_d  = '{opacity: req_i.right.opa, exact_hit: 1'b0};
            done_d = 1'b1;
          end else begin
            state_d = BL_MUL1;
          end
        end
      end
      BL_MUL1: begin
        prod_d  = mul_p;
        state_d = BL_MUL2;
      end
      BL_MUL2: begin
        // The numerator stays below w * 2^VALUE_BITS, so its top half is the
        // first partial remainder.
        rem_d   = num_sum[PROD_W-1:VALUE_BITS];
        lo_d    = num_sum[VALUE_BITS-1:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = BL_DIV;
      end
      BL_DIV: begin
        rem_d = qbit ? trial_sub[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
        lo_d  = {lo_q[VALUE_BITS-2:0], 1'b0};
        quo_d = {quo_q[VALUE_BITS-2:0], qbit};
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          rsp_d   = '{opacity: {quo_q[VALUE_BITS-2:0], qbit}, exact_hit: 1'b0};
          done_d  = 1'b1;
          state_d = BL_IDLE;
        end
      end
      default: begin
        state_d = BL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q  <= rsp_d;
    req_q  <= req_d;
    w_q    <= w_d;
    d_q    <= d_d;
    wd_q   <= wd_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[rtl/piecewise_linear_opacity_lookup_top.sv]
// Top level of the piecewise-linear opacity lookup: knot memory, scan control
// and result register. Depends on plol_pkg, plol_ram and plol_blend.
`timescale 1ns / 1ps

// A request is taken when start_i is high and busy_o is low. A knot write
// produces no result. A lookup walks the knot memory from knot 0 upward, one
// entry per cycle through the single read port, until it finds the first knot
// at index 1 or above whose position is at least the query (or reaches the
// last knot in use). That knot is the right end of the segment, the entry
// read just before it the left end. An exact hit or a clamped query is then
// answered by the blend unit without the multiplier or the divider; a true
// interpolation takes two passes through the shared multiplier and the
// sixteen steps of the bit-serial divider. The result appears on opacity_o,
// exact_hit_o and segment_end_o for exactly one cycle while result_valid_o is
// high; the receiver cannot hold it off, so it must sample it in that cycle.
// The knots_in_use register is written over the cfg channel only while busy_o
// is low; values below 2 act as 2 and values above the table size act as the
// table size. The knot memory is not cleared at reset: a lookup must only
// reach knots that were written.

module piecewise_linear_opacity_lookup_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request channel.
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   operation_i,
  input  plol_pkg::index_t       knot_index_i,
  input  plol_pkg::value_t       knot_position_i,
  input  plol_pkg::value_t       knot_opacity_i,
  input  plol_pkg::value_t       query_value_i,
  // Result channel.
  output logic                   result_valid_o,
  output plol_pkg::value_t       opacity_o,
  output logic                   exact_hit_o,
  output plol_pkg::index_t       segment_end_o,
  // Configuration channel for knots_in_use.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [plol_pkg::CNT_W-1:0] cfg_data_i
);
  import plol_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_BLEND = 2'd2;

  logic [1:0] state_q, state_d;
  index_t     last_q, last_d;    // Index of the last knot in use.
  index_t     addr_q, addr_d;    // Next read address.
  index_t     idx_q, idx_d;      // Index of the entry on the read data.
  value_t     query_q, query_d;
  knot_t      prev_q, prev_d;    // Entry read just before the one on the read data.
  index_t     seg_q, seg_d;

  logic       res_valid_q, res_valid_d;
  blend_rsp_t res_q, res_d;
  index_t     res_seg_q, res_seg_d;

  logic       accept;
  logic       ram_we, ram_re;
  index_t     ram_raddr;
  logic [KNOT_W-1:0] ram_rdata;
  knot_t      rknot;
  logic       seg_found;

  logic       blend_start;
  blend_req_t blend_req;
  logic       blend_done;
  blend_rsp_t blend_rsp;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = !busy_o;

  // Clamp the register value once, at write time, to the last usable index.
  always_comb begin
    priority if (cfg_data_i < CNT_W'(2)) begin
      last_d = IDX_W'(1);
    end else if (cfg_data_i > CNT_W'(MAX_KNOTS)) begin
      last_d = IDX_W'(MAX_KNOTS - 1);
    end else begin
      last_d = IDX_W'(cfg_data_i - CNT_W'(1));
    end
  end

  // Knot writes go straight into the memory on the accepting edge, so a later
  // lookup always reads the new contents.
  assign ram_we    = accept && (operation_i == OP_WRITE);
  assign ram_re    = (accept && (operation_i == OP_LOOKUP)) || (state_q == ST_SCAN);
  assign ram_raddr = (state_q == ST_SCAN) ? addr_q : '0;

  plol_ram #(
    .WIDTH (KNOT_W),
    .DEPTH (MAX_KNOTS)
  ) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (knot_index_i),
    .wdata_i ({knot_position_i, knot_opacity_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rknot = knot_t'(ram_rdata);

  // The right knot is the first one from index 1 whose position is at least
  // the query, or the last knot in use when none is.
  assign seg_found = (state_q == ST_SCAN) && (idx_q != '0) &&
                     ((query_q <= rknot.pos) || (idx_q == last_q));

  assign blend_start = seg_found;
  assign blend_req   = '{query: query_q, left: prev_q, right: rknot};

  plol_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blend_start),
    .req_i   (blend_req),
    .done_o  (blend_done),
    .rsp_o   (blend_rsp)
  );

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    idx_d       = idx_q;
    query_d     = query_q;
    prev_d      = prev_q;
    seg_d       = seg_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    res_seg_d   = res_seg_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (operation_i == OP_LOOKUP)) begin
          query_d = query_value_i;
          addr_d  = IDX_W'(1);
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        prev_d = rknot;
        addr_d = addr_q + IDX_W'(1);
        idx_d  = idx_q + IDX_W'(1);
        if (seg_found) begin
          seg_d   = idx_q;
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (blend_done) begin
          res_valid_d = 1'b1;
          res_d       = blend_rsp;
          res_seg_d   = seg_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= IDX_W'(1);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        last_q <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    idx_q     <= idx_d;
    query_q   <= query_d;
    prev_q    <= prev_d;
    seg_q     <= seg_d;
    res_q     <= res_d;
    res_seg_q <= res_seg_d;
  end

  assign result_valid_o = res_valid_q;
  assign opacity_o      = res_q.opacity;
  assign exact_hit_o    = res_q.exact_hit;
  assign segment_end_o  = res_seg_q;

  // A result only follows a finished blend.
  a_result_after_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_BLEND))
    else $error("result strobe without a finished blend");

  // The scan never runs past the last knot in use.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= last_q))
    else $error("scan ran past the last knot in use");

  // The reported segment end lies between 1 and the last knot in use.
  a_segment_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((segment_end_o != '0) && (segment_end_o <= last_q)))
    else $error("segment end out of range");

  // The blend unit finishes only while the control waits for it.
  a_blend_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_done |-> (state_q == ST_BLEND))
    else $error("blend finished while not awaited");

endmodule
